// ===== rtl/core/utf8e_pkg.sv =====
// Package for the UTF-16 to UTF-8 encoder: item types of the input and result channels
// and the code point constants. No dependencies.
package utf8e_pkg;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        string_end;
  } unit_item_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       last_byte;
  } byte_item_t;

  localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
  localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [20:0] MAX_ONE      = 21'h7F;
  localparam logic [20:0] MAX_TWO      = 21'h7FF;
  localparam logic [20:0] MAX_THREE    = 21'hFFFF;
  localparam logic [7:0]  LEAD_TWO     = 8'hC0;
  localparam logic [7:0]  LEAD_THREE   = 8'hE0;
  localparam logic [7:0]  LEAD_FOUR    = 8'hF0;
  localparam logic [7:0]  CONT_MARK    = 8'h80;

endpackage

// ===== rtl/core/utf16_to_utf8_encoder.sv =====
// UTF-16 to UTF-8 encoder top level: input register, surrogate pairing, encoder and
// byte shift-out buffer. Depends on utf8e_pkg.

// Takes one UTF-16 code unit per item and gives its UTF-8 bytes one per cycle while
// out_stall is low, with last_byte set on the final byte of each unit. A high surrogate
// gives no bytes; it is held as a pending code point and combined with the next low
// surrogate. A lone low surrogate encodes as the small value unit - 0xDC00, and an
// unpaired high surrogate is dropped by the next unit that is not a low surrogate, or by
// string_end. A unit holds the result channel until all its bytes (1 to 4, 4 for a
// surrogate pair) have gone out; the one-byte-wide result port sets that limit. A high
// surrogate retires even while bytes are still shifting out. The input register and the
// byte buffer lie between input accept and the first byte. While the byte buffer waits
// on a stalled output, the input register holds one more unit and then stalls the input;
// high surrogates still pass through it.
module utf16_to_utf8_encoder
  import utf8e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  unit_item_t in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output byte_item_t out_data
);

  // input register
  logic       s1_valid;
  unit_item_t s1_item;

  // pending code point from a high surrogate
  logic [20:0] pending_code;
  logic [20:0] pending_code_next;

  // byte buffer: entry 0 is on the output, rem counts the bytes behind it
  logic       buf_valid;
  logic [7:0] buf_bytes [4];
  logic [1:0] buf_rem;

  logic       out_take;
  logic       buf_free;
  logic       is_high;
  logic       is_low;
  logic       s1_go;
  logic       load;
  logic [20:0] cp;
  logic [7:0] enc_bytes [4];
  logic [1:0] enc_rem;

  assign out_take = buf_valid && !out_stall;
  // buffer can take a new unit if empty or its final byte leaves this cycle
  assign buf_free = !buf_valid || (out_take && (buf_rem == 2'd0));

  assign is_high = (s1_item.code_unit >= HIGH_SURR_LO) && (s1_item.code_unit <= HIGH_SURR_HI);
  assign is_low  = (s1_item.code_unit >= LOW_SURR_LO) && (s1_item.code_unit <= LOW_SURR_HI);

  // high surrogates only touch the pending value, so they never wait on the buffer
  assign s1_go    = s1_valid && (is_high || buf_free);
  assign load     = s1_go && !is_high;
  assign in_stall = s1_valid && !s1_go;

  // code point to encode; pending low ten bits are always zero
  assign cp = is_low ? (pending_code | {11'd0, s1_item.code_unit[9:0]})
                     : {5'd0, s1_item.code_unit};

  always_comb begin
    if (is_high) begin
      pending_code_next = {1'b0, s1_item.code_unit[9:0], 10'd0} + SUPP_BASE;
    end else begin
      pending_code_next = '0;
    end
    if (s1_item.string_end) begin
      pending_code_next = '0;
    end
  end

  always_comb begin
    enc_bytes[0] = '0;
    enc_bytes[1] = '0;
    enc_bytes[2] = '0;
    enc_bytes[3] = '0;
    if (cp <= MAX_ONE) begin
      enc_rem      = 2'd0;
      enc_bytes[0] = cp[7:0];
    end else if (cp <= MAX_TWO) begin
      enc_rem      = 2'd1;
      enc_bytes[0] = LEAD_TWO | {3'd0, cp[10:6]};
      enc_bytes[1] = CONT_MARK | {2'd0, cp[5:0]};
    end else if (cp <= MAX_THREE) begin
      enc_rem      = 2'd2;
      enc_bytes[0] = LEAD_THREE | {4'd0, cp[15:12]};
      enc_bytes[1] = CONT_MARK | {2'd0, cp[11:6]};
      enc_bytes[2] = CONT_MARK | {2'd0, cp[5:0]};
    end else begin
      enc_rem      = 2'd3;
      enc_bytes[0] = LEAD_FOUR | {5'd0, cp[20:18]};
      enc_bytes[1] = CONT_MARK | {2'd0, cp[17:12]};
      enc_bytes[2] = CONT_MARK | {2'd0, cp[11:6]};
      enc_bytes[3] = CONT_MARK | {2'd0, cp[5:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      pending_code <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        pending_code <= pending_code_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      buf_rem   <= '0;
    end else if (load) begin
      buf_valid <= 1'b1;
      buf_rem   <= enc_rem;
    end else if (out_take) begin
      if (buf_rem == 2'd0) begin
        buf_valid <= 1'b0;
      end else begin
        buf_rem <= buf_rem - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_bytes <= enc_bytes;
    end else if (out_take) begin
      buf_bytes[0] <= buf_bytes[1];
      buf_bytes[1] <= buf_bytes[2];
      buf_bytes[2] <= buf_bytes[3];
      buf_bytes[3] <= '0;
    end
  end

  assign out_valid          = buf_valid;
  assign out_data.utf8_byte = buf_bytes[0];
  assign out_data.last_byte = (buf_rem == 2'd0);

endmodule

// ===== verif/utf8_byte_checker.sv =====
// Checker for the UTF-16 to UTF-8 encoder: watches both channels, predicts the UTF-8
// bytes of every accepted unit and compares each accepted byte with the oldest one owed.
// Depends on utf8e_pkg.
module utf8_byte_checker
  import utf8e_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  unit_item_t in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  byte_item_t out_data,
  output int         fail_count,
  output int         bytes_owed
);

  byte_item_t  owed_q[$];
  byte_item_t  want;
  logic [20:0] pending_cp;

  task automatic owe_byte(input logic [7:0] b, input logic last);
    byte_item_t item;
    item.utf8_byte = b;
    item.last_byte = last;
    owed_q.push_back(item);
  endtask

  task automatic owe_utf8(input logic [20:0] cp);
    if (cp <= MAX_ONE) begin
      owe_byte(cp[7:0], 1'b1);
    end else if (cp <= MAX_TWO) begin
      owe_byte(LEAD_TWO | {3'b000, cp[10:6]}, 1'b0);
      owe_byte(CONT_MARK | {2'b00, cp[5:0]}, 1'b1);
    end else if (cp <= MAX_THREE) begin
      owe_byte(LEAD_THREE | {4'h0, cp[15:12]}, 1'b0);
      owe_byte(CONT_MARK | {2'b00, cp[11:6]}, 1'b0);
      owe_byte(CONT_MARK | {2'b00, cp[5:0]}, 1'b1);
    end else begin
      owe_byte(LEAD_FOUR | {5'h00, cp[20:18]}, 1'b0);
      owe_byte(CONT_MARK | {2'b00, cp[17:12]}, 1'b0);
      owe_byte(CONT_MARK | {2'b00, cp[11:6]}, 1'b0);
      owe_byte(CONT_MARK | {2'b00, cp[5:0]}, 1'b1);
    end
  endtask

  task automatic predict_unit(input unit_item_t u);
    logic [15:0] cu;
    cu = u.code_unit;
    if (cu >= HIGH_SURR_LO && cu <= HIGH_SURR_HI) begin
      // high half: park the code point, nothing goes out
      pending_cp = ({5'd0, cu - HIGH_SURR_LO} << 10) + SUPP_BASE;
    end else if (cu >= LOW_SURR_LO && cu <= LOW_SURR_HI) begin
      owe_utf8(pending_cp | {5'd0, cu - LOW_SURR_LO});
      pending_cp = '0;
    end else begin
      owe_utf8({5'd0, cu});
      pending_cp = '0;
    end
    if (u.string_end) pending_cp = '0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pending_cp = '0;
      owed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          $error("unexpected byte utf8_byte %h last_byte %b",
                 out_data.utf8_byte, out_data.last_byte);
          fail_count++;
        end else begin
          want = owed_q.pop_front();
          if (out_data.utf8_byte !== want.utf8_byte) begin
            $error("utf8_byte expected %h actual %h", want.utf8_byte, out_data.utf8_byte);
            fail_count++;
          end
          if (out_data.last_byte !== want.last_byte) begin
            $error("last_byte expected %b actual %b", want.last_byte, out_data.last_byte);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) predict_unit(in_data);
    end
    bytes_owed = owed_q.size();
  end

endmodule

// ===== verif/utf16_to_utf8_encoder_tb.sv =====
// Testbench top for the UTF-16 to UTF-8 encoder: clock, reset, unit stimulus and
// random output stalls; checking is done by utf8_byte_checker. Depends on utf8e_pkg.
module utf16_to_utf8_encoder_tb;
  import utf8e_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  unit_item_t in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  byte_item_t out_data;

  int fail_count;
  int bytes_owed;

  // Handshake seen at the last rising edge; the driving processes look at these at
  // the falling edge, so they never race the block's own register updates.
  logic unit_took = 1'b0;
  logic byte_took = 1'b0;

  bit calm = 1'b0;          // no sender gaps and no random receiver holds while set
  bit hold_request = 1'b0;  // asks the receiver for one long hold
  int units_sent = 0;

  // Directed units as {code_unit, string_end}.
  logic [16:0] warm_units [0:23] = '{
    {16'h0000, 1'b0},   // smallest one-byte value
    {16'h007F, 1'b0},   // largest one-byte value
    {16'h0080, 1'b0},   // smallest two-byte value
    {16'h07FF, 1'b0},   // largest two-byte value
    {16'h0800, 1'b0},   // smallest three-byte value
    {16'hD7FF, 1'b0},   // just below the surrogates
    {16'hE000, 1'b0},   // just above the surrogates
    {16'hFFFF, 1'b1},   // top unit, ends a string
    {16'hAAAA, 1'b0},
    {16'h5555, 1'b0},
    {16'hD800, 1'b0},   // pair giving U+10000
    {16'hDC00, 1'b0},
    {16'hDBFF, 1'b0},   // pair giving U+10FFFF
    {16'hDFFF, 1'b1},
    {16'hDC00, 1'b0},   // lone low half: encodes zero
    {16'hDC7F, 1'b0},   // lone low half, one byte
    {16'hDFFF, 1'b0},   // lone low half, two bytes
    {16'hD800, 1'b0},   // high half dropped by an ordinary unit
    {16'h0041, 1'b0},
    {16'hDA00, 1'b0},   // high half replaced by another high half
    {16'hDB00, 1'b0},
    {16'hDE00, 1'b0},
    {16'hDBFF, 1'b1},   // high half at string end is dropped
    {16'hDC01, 1'b0}    // so this low half stands alone
  };

  always #5 clk = ~clk;

  always @(posedge clk) begin
    unit_took <= in_valid & ~in_stall;
    byte_took <= out_valid & ~out_stall;
  end

  utf16_to_utf8_encoder u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  utf8_byte_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .bytes_owed (bytes_owed)
  );

  // Offer one unit, after a random gap unless calm, and return at the falling edge
  // that follows its acceptance. Valid stays high into the next unit when no gap is
  // drawn, so it is never lowered and raised in one step.
  task automatic send_unit(input logic [15:0] cu, input logic se);
    int         gap;
    unit_item_t item;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.code_unit  = cu;
    item.string_end = se;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(negedge clk); while (!unit_took);
    units_sent++;
  endtask

  // Sender pause: nothing offered until every owed byte has come out and a high half
  // that is still being retired inside has had time to leave.
  task automatic drain_bytes();
    in_valid <= 1'b0;
    while (bytes_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Receiver: a random hold before each byte, or one long hold when asked.
  initial begin
    int hold;
    forever begin
      if (hold_request) begin
        hold = 300;
        hold_request = 1'b0;
      end else begin
        hold = calm ? 0 : $urandom_range(0, 13);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!byte_took);
    end
  end

  initial begin
    logic [15:0] hi;
    logic [15:0] lo;
    logic        se;
    int          pick;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part: range edges, surrogate pairs and the unpaired cases
    foreach (warm_units[i]) send_unit(warm_units[i][16:1], warm_units[i][0]);
    drain_bytes();

    // backpressure: the receiver holds off while four-byte pairs keep coming, so the
    // byte buffer and then the input register fill and in_stall rises
    hold_request = 1'b1;
    calm = 1'b1;
    repeat (12) begin
      send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
      send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), 1'b0);
    end
    calm = 1'b0;
    drain_bytes();

    // random part: mostly well-formed text with random content, the rest noise
    while (units_sent < 470) begin
      if ($urandom_range(0, 29) == 0) calm = ~calm;
      se   = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      hi   = 16'($urandom_range(16'hD800, 16'hDBFF));
      lo   = 16'($urandom_range(16'hDC00, 16'hDFFF));
      if (pick < 20) begin
        send_unit(16'($urandom_range(0, 16'h007F)), se);
      end else if (pick < 32) begin
        send_unit(16'($urandom_range(16'h0080, 16'h07FF)), se);
      end else if (pick < 44) begin
        if ($urandom_range(0, 1) == 0) begin
          send_unit(16'($urandom_range(16'h0800, 16'hD7FF)), se);
        end else begin
          send_unit(16'($urandom_range(16'hE000, 16'hFFFF)), se);
        end
      end else if (pick < 72) begin
        // pair; now and then the string ends on the high half and breaks it
        send_unit(hi, ($urandom_range(0, 15) == 0));
        send_unit(lo, se);
      end else if (pick < 84) begin
        send_unit(16'($urandom_range(0, 16'hFFFF)), se);
      end else if (pick < 92) begin
        send_unit(hi, se);
      end else begin
        send_unit(lo, se);
      end
    end

    // wind down: wait for the last bytes, then leave room for strays before the verdict
    in_valid <= 1'b0;
    while (bytes_owed != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && bytes_owed == 0) begin
      $display("utf16_to_utf8_encoder regression: pass");
    end else begin
      $display("utf16_to_utf8_encoder regression: fail");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("utf16_to_utf8_encoder regression: fail");
    $finish;
  end

endmodule
